### hw/rtl/olrb_pkg.sv
// Package for the overwriting log ring buffer: ring size, pointer width,
// command codes, transaction structs and the controller state encoding.
// No dependencies.
package olrb_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [PTR_W-1:0] ptr_t;

  // Command codes carried in the input transaction. The fourth code is unused
  // and is treated as a no-op.
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REWIND = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic       dropped;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

  // Advance a ring pointer by one, wrapping at the ring size.
  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t n;
    n = (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
    return n;
  endfunction

endpackage

### hw/rtl/overwriting_log_ring_buffer.sv
// Top level of the overwriting log ring buffer: joins the controller and
// the datapath. Depends on olrb_pkg, olrb_ctrl and olrb_datapath.

// Byte log ring of 1024 entries holding up to 1023 bytes; when full, a put
// drops the oldest byte and flags it. Every input transaction (put, get or
// rewind) yields exactly one result transaction. An accepted transaction is
// captured into a register; then the execute state updates the pointers and
// accesses the byte store (one write port and one read port, whose read data
// is registered), and then the done state offers the result. The next
// transaction is accepted in the cycle its predecessor's result is taken, so
// a new transaction is not taken before the last one's result leaves. The
// store needs no clearing after reset.
module overwriting_log_ring_buffer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  olrb_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output olrb_pkg::out_t out_item_o
);
  import olrb_pkg::*;

  ctrl_t ctrl;

  olrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  olrb_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

### hw/rtl/olrb_ctrl.sv
// Controller state machine of the overwriting log ring buffer: sequences
// capture, execution and result hand-off. Depends on olrb_pkg.
module olrb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output olrb_pkg::ctrl_t ctrl_o
);
  import olrb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    ctrl_o.capture = 1'b0;
    ctrl_o.execute = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl_o.execute = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        // When the result leaves, the next transaction may enter in the same cycle.
        if (!out_stall_i) begin
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            ctrl_o.capture = 1'b1;
            state_d        = ST_EXEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/olrb_datapath.sv
// Datapath of the overwriting log ring buffer: the byte store, the three
// ring pointers and the result registers. Depends on olrb_pkg.
module olrb_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  olrb_pkg::ctrl_t ctrl_i,
  input  olrb_pkg::in_t   in_item_i,
  output olrb_pkg::out_t  out_item_o
);
  import olrb_pkg::*;

  logic [7:0] log_store [DEPTH];

  in_t        item_q;
  ptr_t       wr_ptr_q, wr_ptr_d;
  ptr_t       old_ptr_q, old_ptr_d;
  ptr_t       rd_cur_q, rd_cur_d;
  logic [7:0] rdata_q;
  logic       rvalid_q, rvalid_d;
  logic       drop_q, drop_d;
  logic       wr_en;
  logic       full;

  assign full = (ring_next(wr_ptr_q) == old_ptr_q);

  always_comb begin
    wr_ptr_d  = wr_ptr_q;
    old_ptr_d = old_ptr_q;
    rd_cur_d  = rd_cur_q;
    rvalid_d  = 1'b0;
    drop_d    = 1'b0;
    wr_en     = 1'b0;
    case (item_q.command)
      CMD_PUT: begin
        wr_en    = 1'b1;
        wr_ptr_d = ring_next(wr_ptr_q);
        if (full) begin
          // Drop the oldest byte; a cursor parked on it moves along with it.
          drop_d    = 1'b1;
          old_ptr_d = ring_next(old_ptr_q);
          if (rd_cur_q == old_ptr_q) begin
            rd_cur_d = ring_next(old_ptr_q);
          end
        end
      end
      CMD_GET: begin
        if (rd_cur_q != wr_ptr_q) begin
          rvalid_d = 1'b1;
          rd_cur_d = ring_next(rd_cur_q);
        end
      end
      CMD_REWIND: begin
        rd_cur_d = old_ptr_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      old_ptr_q <= '0;
      rd_cur_q  <= '0;
      rvalid_q  <= 1'b0;
      drop_q    <= 1'b0;
    end else if (ctrl_i.execute) begin
      wr_ptr_q  <= wr_ptr_d;
      old_ptr_q <= old_ptr_d;
      rd_cur_q  <= rd_cur_d;
      rvalid_q  <= rvalid_d;
      drop_q    <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // Byte store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute && wr_en) begin
      log_store[wr_ptr_q] <= item_q.data_byte;
    end
    if (ctrl_i.execute) begin
      rdata_q <= log_store[rd_cur_q];
    end
  end

  assign out_item_o.read_byte  = rvalid_q ? rdata_q : 8'd0;
  assign out_item_o.read_valid = rvalid_q;
  assign out_item_o.dropped    = drop_q;

endmodule
